@@ design/ray_halfspace_span_assert.svh @@
// assertion macros for the port-level checker file
`ifndef RAY_HALFSPACE_SPAN_ASSERT_SVH
`define RAY_HALFSPACE_SPAN_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RHS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhs assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define RHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhs assertion failed");

`endif

@@ design/rhs_pkg.sv @@
// types, codes and helpers for the ray/plane span block
package rhs_pkg;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_WHOLE  = 2'd1,
    KIND_FROM_T = 2'd2,
    KIND_TO_T   = 2'd3
  } kind_t;

  localparam logic [2:0] REG_NORMAL_X  = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_NEAR_ZERO = 3'd4;
  localparam logic [2:0] REG_MAX_T     = 3'd5;

  localparam int QBITS = 32;

  localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SUM_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] offset;
    logic [62:0]        near_zero;
  } plane_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  // one slot of the divider chain
  typedef struct packed {
    logic        valid;
    logic [63:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [62:0] den;
    logic        par;
    logic        ovf;
    logic        nz;
    logic        neg;
    logic        dneg;
  } cell_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > SUM_MAX) return SUM_MAX[63:0];
    if (s < SUM_MIN) return SUM_MIN[63:0];
    return s[63:0];
  endfunction

endpackage

@@ design/rhs_ifs.sv @@
// ray input and span output channels
interface ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface span_if;
  logic               valid;
  logic               ready;
  logic [1:0]         span_kind;
  logic signed [31:0] hit_t;
  modport source (output valid, span_kind, hit_t, input ready);
  modport sink (input valid, span_kind, hit_t, output ready);
endinterface

@@ design/rhs_front.sv @@
// products, saturating dot sums and divider setup
module rhs_front
  import rhs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  ray_t   ray,
  input  plane_t plane,
  output cell_t  head
);

  // stage 1: products
  logic v1;
  logic signed [63:0] p_dx, p_dy, p_dz, p_ox, p_oy, p_oz, p_off;
  // stage 2
  logic v2;
  logic signed [63:0] d2, n2, dz2, noy2, noz2;
  // stage 3
  logic v3;
  logic signed [63:0] d3, n3, noz3;
  // stage 4
  logic v4;
  logic signed [63:0] d4, n4;

  logic [62:0] adiv, anum;

  assign adiv = d4[63] ? 63'(-d4) : d4[62:0];
  assign anum = n4[63] ? 63'(-n4) : n4[62:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      head.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      head.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_dx  <= ray.dir_x * plane.normal_x;
      p_dy  <= ray.dir_y * plane.normal_y;
      p_dz  <= ray.dir_z * plane.normal_z;
      p_ox  <= ray.origin_x * plane.normal_x;
      p_oy  <= ray.origin_y * plane.normal_y;
      p_oz  <= ray.origin_z * plane.normal_z;
      p_off <= $signed({{16{plane.offset[31]}}, plane.offset, 16'h0000});

      d2   <= sat_add(p_dx, p_dy);
      n2   <= sat_add(-p_off, -p_ox);
      dz2  <= p_dz;
      noy2 <= -p_oy;
      noz2 <= -p_oz;

      d3   <= sat_add(d2, dz2);
      n3   <= sat_add(n2, noy2);
      noz3 <= noz2;

      d4 <= d3;
      n4 <= sat_add(n3, noz3);

      head.rem  <= {17'h0, anum[62:16]};
      head.low  <= {anum[15:0], 16'h0000};
      head.quo  <= '0;
      head.den  <= adiv;
      head.par  <= (adiv == '0) || (adiv < plane.near_zero);
      head.ovf  <= {16'h0000, anum} >= {adiv, 16'h0000};
      head.nz   <= anum < plane.near_zero;
      head.neg  <= n4[63] != d4[63];
      head.dneg <= d4[63];
    end
  end

endmodule

@@ design/rhs_div_cell.sv @@
// one quotient bit of the restoring divider
module rhs_div_cell
  import rhs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t prev,
  output cell_t next
);

  logic [63:0] shifted;
  logic        fits;

  assign shifted = {prev.rem[62:0], prev.low[31]};
  assign fits    = shifted >= {1'b0, prev.den};

  always_ff @(posedge clk) begin
    if (rst) begin
      next.valid <= 1'b0;
    end else if (en) begin
      next.valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next.rem  <= fits ? shifted - {1'b0, prev.den} : shifted;
      next.low  <= {prev.low[30:0], 1'b0};
      next.quo  <= {prev.quo[30:0], fits};
      next.den  <= prev.den;
      next.par  <= prev.par;
      next.ovf  <= prev.ovf;
      next.nz   <= prev.nz;
      next.neg  <= prev.neg;
      next.dneg <= prev.dneg;
    end
  end

endmodule

@@ design/ray_halfspace_span.sv @@
// top level: ray against configured plane, span of the far side
//
//   channel | dir | transfer carries
//   --------+-----+---------------------------------------------
//   ray     | in  | origin_x/y/z, dir_x/y/z (Q16.16 signed)
//   span    | out | span_kind, hit_t (Q16.16 signed)
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// one ray per cycle sustained while the skid slot is empty; ray transfer to span valid runs
// through 5 front stages, 32 divider cells and the output register
// the divider chain resolves one quotient bit per cell
// rst clears config to plane z = 0 and empties every stage
// output register plus one skid slot; the chain halts only when both are full
module ray_halfspace_span
  import rhs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [62:0]  cfg_data,
  ray_if.sink          ray,
  span_if.source       span
);

  // config registers
  plane_t      plane;
  logic [30:0] max_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane.normal_x  <= '0;
      plane.normal_y  <= '0;
      plane.normal_z  <= 32'sd65536;
      plane.offset    <= '0;
      plane.near_zero <= 63'd1;
      max_t           <= 31'h7FFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_X:  plane.normal_x  <= cfg_data[31:0];
        REG_NORMAL_Y:  plane.normal_y  <= cfg_data[31:0];
        REG_NORMAL_Z:  plane.normal_z  <= cfg_data[31:0];
        REG_OFFSET:    plane.offset    <= cfg_data[31:0];
        REG_NEAR_ZERO: plane.near_zero <= cfg_data;
        REG_MAX_T:     max_t           <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // whole chain advances while the skid slot is empty
  logic en;
  logic skid_valid;
  assign en        = !skid_valid;
  assign ray.ready = en;

  ray_t ray_in;
  assign ray_in.origin_x = ray.origin_x;
  assign ray_in.origin_y = ray.origin_y;
  assign ray_in.origin_z = ray.origin_z;
  assign ray_in.dir_x    = ray.dir_x;
  assign ray_in.dir_y    = ray.dir_y;
  assign ray_in.dir_z    = ray.dir_z;

  cell_t chain [QBITS+1];

  rhs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ray.valid),
    .ray      (ray_in),
    .plane    (plane),
    .head     (chain[0])
  );

  // divider: one cell per quotient bit, msb first
  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    rhs_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (chain[i]),
      .next (chain[i+1])
    );
  end

  // classify the finished item
  cell_t       tail;
  logic        parallel;
  kind_t       kind;
  logic [31:0] t_val;

  assign tail     = chain[QBITS];
  assign parallel = tail.par || tail.ovf || (tail.quo >= {1'b0, max_t});

  always_comb begin
    if (parallel) begin
      kind  = tail.nz ? KIND_WHOLE : KIND_NONE;
      t_val = '0;
    end else begin
      kind  = tail.dneg ? KIND_FROM_T : KIND_TO_T;
      t_val = tail.neg ? -tail.quo : tail.quo;
    end
  end

  // output register and skid slot
  logic        out_valid;
  kind_t       out_kind, skid_kind;
  logic [31:0] out_t, skid_t;
  logic        out_free;
  logic        arrive;

  assign out_free = !out_valid || span.ready;
  assign arrive   = en && tail.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= arrive;
      end
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_kind <= skid_kind;
        out_t    <= skid_t;
      end else begin
        out_kind <= kind;
        out_t    <= t_val;
      end
    end else if (arrive) begin
      skid_kind <= kind;
      skid_t    <= t_val;
    end
  end

  assign span.valid     = out_valid;
  assign span.span_kind = out_kind;
  assign span.hit_t     = out_t;

endmodule

@@ design/rhs_checker.sv @@
// port-level checks for the span block, bound to the top level
module rhs_checker
  import rhs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        ray_ready,
  input logic        span_valid,
  input logic        span_ready,
  input logic [1:0]  span_kind,
  input logic [31:0] hit_t
);

`include "ray_halfspace_span_assert.svh"

  // a held result keeps its payload
  `RHS_ASSERT_NEXT(a_span_hold, span_valid && !span_ready, span_valid && $stable(span_kind) && $stable(hit_t))

  // kinds without a crossing report zero distance
  `RHS_ASSERT_IMPL(a_zero_t, span_valid && (span_kind == KIND_NONE || span_kind == KIND_WHOLE), hit_t == 32'h0)

  // skid slot only fills behind a held output
  `RHS_ASSERT_IMPL(a_ready_idle, !span_valid, ray_ready)

endmodule

bind ray_halfspace_span rhs_checker u_rhs_checker (
  .clk        (clk),
  .rst        (rst),
  .ray_ready  (ray.ready),
  .span_valid (span.valid),
  .span_ready (span.ready),
  .span_kind  (span.span_kind),
  .hit_t      (span.hit_t)
);

@@ tb/rhs_span_checker.sv @@
`timescale 1ns / 1ps
// span checker: follows config writes, predicts each ray's span, compares transfers
module rhs_span_checker
  import rhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data,
  ray_if              ray,
  span_if             span,
  output int          err_count,
  output int          pending
);

  typedef struct {
    kind_t       kind;
    logic [31:0] t;
  } span_exp_t;

  logic signed [31:0] pl_nx, pl_ny, pl_nz, pl_off;
  logic [62:0]        pl_near;
  logic [30:0]        pl_max_t;

  span_exp_t span_q[$];
  int        errs;

  assign err_count = errs;
  assign pending   = span_q.size();

  function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -64'sh7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic span_exp_t predict_span(input logic signed [31:0] ox, oy, oz,
                                             input logic signed [31:0] dx, dy, dz);
    span_exp_t          e;
    logic signed [63:0] den, num;
    logic [63:0]        aden, anum;
    logic [79:0]        quo;
    logic               par;
    den = 64'(dx) * 64'(pl_nx);
    den = add_clamp(den, 64'(dy) * 64'(pl_ny));
    den = add_clamp(den, 64'(dz) * 64'(pl_nz));
    num = -(64'(pl_off) * 64'sd65536);
    num = add_clamp(num, -(64'(ox) * 64'(pl_nx)));
    num = add_clamp(num, -(64'(oy) * 64'(pl_ny)));
    num = add_clamp(num, -(64'(oz) * 64'(pl_nz)));
    aden = den[63] ? -den : den;
    anum = num[63] ? -num : num;
    // zero divisor is parallel even with a zero limit
    par = (aden == 0) || (aden < {1'b0, pl_near});
    quo = '0;
    if (!par) begin
      quo = {anum, 16'b0} / {16'b0, aden};
      if (quo >= {49'b0, pl_max_t}) par = 1'b1;
    end
    if (par) begin
      e.kind = (anum < {1'b0, pl_near}) ? KIND_WHOLE : KIND_NONE;
      e.t    = '0;
    end else begin
      e.t    = (num[63] != den[63]) ? -quo[31:0] : quo[31:0];
      e.kind = den[63] ? KIND_FROM_T : KIND_TO_T;
    end
    return e;
  endfunction

  always @(posedge clk) begin
    span_exp_t e;
    if (rst) begin
      pl_nx    <= 32'sd0;
      pl_ny    <= 32'sd0;
      pl_nz    <= 32'sd65536;
      pl_off   <= 32'sd0;
      pl_near  <= 63'd1;
      pl_max_t <= 31'h7FFF_FFFF;
      span_q.delete();
      errs = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NORMAL_X:  pl_nx    <= cfg_data[31:0];
          REG_NORMAL_Y:  pl_ny    <= cfg_data[31:0];
          REG_NORMAL_Z:  pl_nz    <= cfg_data[31:0];
          REG_OFFSET:    pl_off   <= cfg_data[31:0];
          REG_NEAR_ZERO: pl_near  <= cfg_data;
          REG_MAX_T:     pl_max_t <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (ray.valid && ray.ready)
        span_q.push_back(predict_span(ray.origin_x, ray.origin_y, ray.origin_z,
                                      ray.dir_x, ray.dir_y, ray.dir_z));
      if (span.valid && span.ready) begin
        if (span_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected span transfer: kind %0d t %h",
                                   span.span_kind, span.hit_t);
        end else begin
          e = span_q.pop_front();
          if (span.span_kind !== e.kind || span.hit_t !== e.t) begin
            errs++;
            if (errs <= 10)
              $display("span mismatch: kind exp %0d got %0d, t exp %h got %h",
                       e.kind, span.span_kind, e.t, span.hit_t);
          end
        end
      end
    end
  end

endmodule

@@ tb/tb_ray_halfspace_span.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, plane settings, ray stimulus and verdict
module tb_ray_halfspace_span
  import rhs_pkg::*;
();

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 45;  // longer than the pipe from ray to span

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [62:0] cfg_data;
  int          err_count;
  int          pending;
  bit          hold_req;

  ray_if  ray ();
  span_if span ();

  ray_halfspace_span u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ray       (ray),
    .span      (span)
  );

  rhs_span_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ray       (ray),
    .span      (span),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // a Q16.16 coordinate: full range, scaled down, zero or an extreme
  function automatic logic [31:0] pick_coord();
    logic signed [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1:    return v;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return '0;
      default: return v >>> $urandom_range(6, 26);
    endcase
  endfunction

  // receiver: random ready, plus one long hold-off on request
  initial begin
    int n;
    span.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        span.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = pick_gap();
        span.ready <= (n == 0);
        repeat (n + 1) @(posedge clk);
      end else begin
        span.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one register write per call; caller lowers cfg_we afterwards
  task automatic write_reg(input logic [2:0] idx, input logic [62:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_plane(input logic [31:0] nx, ny, nz, off,
                            input logic [62:0] near, input logic [30:0] mt);
    write_reg(REG_NORMAL_X, {31'b0, nx});
    write_reg(REG_NORMAL_Y, {31'b0, ny});
    write_reg(REG_NORMAL_Z, {31'b0, nz});
    write_reg(REG_OFFSET, {31'b0, off});
    write_reg(REG_NEAR_ZERO, near);
    write_reg(REG_MAX_T, {32'b0, mt});
    // out of range index must leave the plane alone
    write_reg(REG_UNUSED, 63'({$urandom, $urandom}));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // offer one ray after a gap; returns once the transfer has happened
  task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, input int gap);
    if (gap > 0) begin
      ray.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ray.valid    <= 1'b1;
    ray.origin_x <= ox;
    ray.origin_y <= oy;
    ray.origin_z <= oz;
    ray.dir_x    <= dx;
    ray.dir_y    <= dy;
    ray.dir_z    <= dz;
    @(negedge clk);
    while (!ray.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_ray();
    send_ray(pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_gap());
  endtask

  // wait for every span to come back and the pipe to settle
  task automatic drain();
    ray.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [31:0] one;
    one = 32'h0001_0000;
    hold_req     = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    ray.valid    = 1'b0;
    ray.origin_x = '0;
    ray.origin_y = '0;
    ray.origin_z = '0;
    ray.dir_x    = '0;
    ray.dir_y    = '0;
    ray.dir_z    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rays on the reset plane z = 0
    send_ray('0, '0, one, '0, '0, -one, 0);              // from t to +inf
    send_ray('0, '0, one, '0, '0, one, 0);               // -inf to t
    send_ray('0, '0, '0, one, '0, '0, 1);                // parallel in plane: whole
    send_ray('0, '0, one, one, one, '0, 0);              // parallel off plane: none
    send_ray('0, '0, 32'h7FFF_FFFF, '0, '0, 32'h0000_0001, 2);  // huge t: parallel
    send_ray('0, '0, 32'h8000_0000, '0, '0, 32'h7FFF_FFFF, 0);
    send_ray('0, '0, 32'h7FFF_FFFF, '0, '0, 32'h8000_0000, 0);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_ray('0, '0, -one, '0, '0, -one, 0);             // negative t
    send_ray('0, '0, 32'h0003_8000, '0, '0, 32'hFFFF_C000, 3);
    send_ray('0, '0, '0, '0, '0, '0, 0);                 // zero direction
    drain();

    // sums that saturate, zero limit with zero divisor
    load_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               63'd0, 31'h7FFF_FFFF);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_ray('0, '0, '0, '0, '0, '0, 0);
    send_ray(one, '0, '0, '0, '0, '0, 0);
    drain();

    // several plane settings, extremes among them; long hold-off in the first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_plane($urandom >>> 12, $urandom >>> 12, $urandom >>> 12,
                      $urandom >>> 8, 63'd1, 31'h7FFF_FFFF);
        1: load_plane($urandom, $urandom, $urandom, $urandom,
                      63'({$urandom, $urandom} >> $urandom_range(20, 50)),
                      31'($urandom));
        2: load_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000,
                      63'h7FFF_FFFF_FFFF_FFFF, 31'd0);
        3: load_plane(one, '0, '0, '0, 63'd0, 31'd0);
        4: load_plane($urandom >>> 16, $urandom >>> 16, $urandom >>> 16,
                      $urandom >>> 16, 63'd1 << 32, 31'h0100_0000);
        default: load_plane($urandom >>> 4, $urandom >>> 4, $urandom >>> 4,
                            $urandom, 63'({$urandom, $urandom} >> 30),
                            31'h7FFF_FFFF);
      endcase
      if (ph == 0) hold_req = 1'b1;
      for (int i = 0; i < 325; i++) send_random_ray();
      drain();
    end

    if (err_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
